// File: sv/mbg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_pkg
// shared codes, field widths and helpers of the maze backtracker generator
// ----------------------------------------------------------------------------
package mbg_pkg;

	localparam int unsigned LimW = 9;

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_READ    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_CARVED   = 2'd0,
		ST_FINISHED = 2'd1,
		ST_WALLS    = 2'd2,
		ST_REJECTED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	localparam logic [3:0] WallsAll = 4'hF;

	// wall removed in the carving cell
	function automatic logic [3:0] near_wall(input logic [1:0] d);
		logic [3:0] m;
		case (d)
			DIR_LEFT:  m = 4'h4;
			DIR_RIGHT: m = 4'h8;
			DIR_UP:    m = 4'h1;
			default:   m = 4'h2;
		endcase
		return m;
	endfunction

	// wall removed in the entered cell
	function automatic logic [3:0] far_wall(input logic [1:0] d);
		logic [3:0] m;
		case (d)
			DIR_LEFT:  m = 4'h8;
			DIR_RIGHT: m = 4'h4;
			DIR_UP:    m = 4'h2;
			default:   m = 4'h1;
		endcase
		return m;
	endfunction

	// direction order after the three swaps, slot i in bits [2i+1:2i]
	function automatic logic [7:0] shuffle(input logic [1:0] p0, input logic [1:0] p1,
			input logic p2);
		logic [1:0] o [4];
		logic [1:0] t;
		logic [2:0] j;
		o[0] = 2'd0; o[1] = 2'd1; o[2] = 2'd2; o[3] = 2'd3;
		j = {1'b0, p0};
		t = o[0]; o[0] = o[j[1:0]]; o[j[1:0]] = t;
		j = 3'd1 + {1'b0, p1};
		if (j > 3'd3) j = 3'd3;
		t = o[1]; o[1] = o[j[1:0]]; o[j[1:0]] = t;
		j = 3'd2 + {2'b0, p2};
		t = o[2]; o[2] = o[j[1:0]]; o[j[1:0]] = t;
		return {o[3], o[2], o[1], o[0]};
	endfunction

	// register value to grid extent: zero acts as one, clamp at the maximum
	function automatic logic [LimW-1:0] eff_extent(input logic [5:0] v,
			input logic [LimW-1:0] mx);
		logic [LimW-1:0] r;
		if (v == 6'd0) r = LimW'(1);
		else if (LimW'(v) > mx) r = mx;
		else r = LimW'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/mbg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mbg_ram #(
	parameter int unsigned AW = 10,
	parameter int unsigned DW = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/mbg_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_step
// shared neighbor unit: one increment or decrement and one bound compare
// ----------------------------------------------------------------------------
module mbg_step
	import mbg_pkg::*;
#(
	parameter int unsigned MW = 5
) (
	input  wire logic [MW-1:0]   coord,
	input  wire logic            dec,
	input  wire logic [LimW-1:0] lim,
	output logic      [MW-1:0]   nb,
	output logic                 ok
);
	logic [MW:0] sum;

	always_comb begin
		sum = dec ? ({1'b0, coord} - (MW+1)'(1)) : ({1'b0, coord} + (MW+1)'(1));
		nb  = sum[MW-1:0];
		// borrow out means the step left the grid on the low side
		ok  = !(dec && sum[MW]) && (LimW'(sum) < lim);
	end
endmodule
`default_nettype wire

// File: sv/maze_backtracker_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maze_backtracker_generator
// randomized depth-first maze carver with an explicit walk stack
// ----------------------------------------------------------------------------
// usage
//   s_* carries command beats (start at cell, advance walk, read cell walls),
//   m_* returns exactly one result beat per command. cfg_* writes the grid
//   rows (index 0) and columns (index 1); the user must do so only while the
//   block is idle, which the block itself does not enforce.
// state sequence, from the accepted command to the loaded result beat
//   read: S_RD, S_OUT. rejected: S_OUT. start: one sweep over all
//   2**(row bits + col bits) cells of the cell memory, S_SPUSH, S_OUT.
//   advance: S_POP and S_LOAD load the top entry, S_TRY per direction tried,
//   S_CHK per in-range neighbor probed, S_TRY, S_POP and S_LOAD per exhausted
//   entry popped, S_CUR and S_OUT to carve. one command is in flight at a time;
//   the next is taken, at the earliest, the cycle after the result is loaded.
// reset
//   arst_n clears control state; afterwards the cell memory is swept to all
//   walls and not visited over its 2**(row bits + col bits) cells, s_tready low.
// stall
//   a result sits in the output register until m_tready; the next command
//   is already taken but its result waits for the output register.
// ----------------------------------------------------------------------------
module maze_backtracker_generator
	import mbg_pkg::*;
#(
	parameter int unsigned MAX_ROWS = 32,
	parameter int unsigned MAX_COLS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// action[1:0] cell_row[6:2] cell_col[11:7] pick_first[13:12]
	// pick_second[15:14] pick_third[16]
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[1:0] from_row[6:2] from_col[11:7] direction[13:12]
	// wall_bits[17:14] seen[18]
	output logic      [23:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [5:0]  cfg_data
);
	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned CW    = $clog2(MAX_COLS);
	localparam int unsigned MW    = (RW > CW) ? RW : CW;
	localparam int unsigned AW    = RW + CW;
	localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
	localparam int unsigned SA    = $clog2(CELLS);
	localparam int unsigned SDW   = $clog2(CELLS + 1);
	localparam int unsigned EW    = RW + CW + 8 + 3;   // row, col, order, tried count

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_SPUSH, S_POP, S_LOAD, S_TRY, S_CHK, S_CUR, S_OUT
	} state_t;

	state_t state_q;

	// config
	logic [5:0] rows_q, cols_q;
	logic [LimW-1:0] erows, ecols;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 6'd32;
			cols_q <= 6'd32;
		end else if (cfg_we) begin
			if (cfg_idx == 1'b0) rows_q <= cfg_data;
			else                 cols_q <= cfg_data;
		end
	end

	assign erows = eff_extent(rows_q, LimW'(MAX_ROWS));
	assign ecols = eff_extent(cols_q, LimW'(MAX_COLS));

	// command fields
	logic [1:0] in_act;
	logic [4:0] in_row, in_col;
	assign in_act = s_tdata[1:0];
	assign in_row = s_tdata[6:2];
	assign in_col = s_tdata[11:7];

	logic [4:0] cmd_row_q, cmd_col_q;
	logic [1:0] pk0_q, pk1_q;
	logic       pk2_q;
	logic       start_q;

	// walk registers
	logic [SDW-1:0] depth_q;
	logic [SA-1:0]  top;
	logic [RW-1:0]  cr_q, nr_q;
	logic [CW-1:0]  cc_q, nc_q;
	logic [7:0]     ord_q;
	logic [2:0]     tried_q;
	logic [1:0]     d_q;
	logic [AW-1:0]  clr_q;

	assign top = SA'(depth_q - SDW'(1));

	// shared neighbor unit
	logic [1:0]      try_dir;
	logic            horiz;
	logic [MW-1:0]   st_coord, st_nb;
	logic            st_ok;

	assign try_dir  = ord_q[2*tried_q[1:0] +: 2];
	assign horiz    = (try_dir == DIR_LEFT) || (try_dir == DIR_RIGHT);
	assign st_coord = horiz ? MW'(cc_q) : MW'(cr_q);

	mbg_step #(.MW(MW)) u_step (
		.coord (st_coord),
		.dec   ((try_dir == DIR_LEFT) || (try_dir == DIR_UP)),
		.lim   (horiz ? ecols : erows),
		.nb    (st_nb),
		.ok    (st_ok)
	);

	// cell memory: {visited, walls}
	logic          cm_we;
	logic [AW-1:0] cm_waddr, cm_raddr;
	logic [4:0]    cm_wdata, cm_rdata;

	always_comb begin
		cm_we    = 1'b0;
		cm_waddr = clr_q;
		cm_wdata = {1'b0, WallsAll};
		cm_raddr = {cr_q, cc_q};
		unique case (state_q)
			S_CLR: cm_we = 1'b1;
			S_IDLE: cm_raddr = {RW'(in_row), CW'(in_col)};
			S_RD: cm_raddr = {RW'(cmd_row_q), CW'(cmd_col_q)};
			S_SPUSH: begin
				cm_we    = 1'b1;
				cm_waddr = {RW'(cmd_row_q), CW'(cmd_col_q)};
				cm_wdata = {1'b1, WallsAll};
			end
			S_TRY: cm_raddr = horiz ? {cr_q, CW'(st_nb)} : {RW'(st_nb), cc_q};
			S_CHK: begin
				cm_we    = !cm_rdata[4];
				cm_waddr = {nr_q, nc_q};
				cm_wdata = {1'b1, cm_rdata[3:0] & ~far_wall(d_q)};
			end
			S_CUR: begin
				cm_we    = 1'b1;
				cm_waddr = {cr_q, cc_q};
				cm_wdata = {cm_rdata[4], cm_rdata[3:0] & ~near_wall(d_q)};
			end
			default: ;
		endcase
	end

	mbg_ram #(.AW(AW), .DW(5)) u_cells (
		.clk   (clk),
		.we    (cm_we),
		.waddr (cm_waddr),
		.wdata (cm_wdata),
		.raddr (cm_raddr),
		.rdata (cm_rdata)
	);

	// walk stack memory
	logic          sk_we;
	logic [SA-1:0] sk_waddr;
	logic [EW-1:0] sk_wdata, sk_rdata;

	always_comb begin
		sk_we    = 1'b0;
		sk_waddr = top;
		sk_wdata = {cr_q, cc_q, ord_q, tried_q};
		unique case (state_q)
			S_SPUSH: begin
				sk_we    = 1'b1;
				sk_waddr = '0;
				sk_wdata = {RW'(cmd_row_q), CW'(cmd_col_q), shuffle(pk0_q, pk1_q, pk2_q),
					3'd0};
			end
			S_CHK: sk_we = !cm_rdata[4];   // save how far the top has tried
			S_CUR: begin
				sk_we    = (depth_q < SDW'(CELLS));
				sk_waddr = SA'(depth_q);
				sk_wdata = {nr_q, nc_q, shuffle(pk0_q, pk1_q, pk2_q), 3'd0};
			end
			default: ;
		endcase
	end

	mbg_ram #(.AW(SA), .DW(EW)) u_stack (
		.clk   (clk),
		.we    (sk_we),
		.waddr (sk_waddr),
		.wdata (sk_wdata),
		.raddr (top),
		.rdata (sk_rdata)
	);

	// sequencer
	logic [18:0] res_q;
	logic        out_free;
	logic        in_grid;

	assign out_free = !m_tvalid || m_tready;
	assign in_grid  = (LimW'(in_row) < erows) && (LimW'(in_col) < ecols);
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			start_q  <= 1'b0;
			depth_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// the output state loads a new beat itself
			if (m_tvalid && m_tready && state_q != S_OUT) m_tvalid <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q <= start_q ? S_SPUSH : S_IDLE;
						start_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_row_q <= in_row;
						cmd_col_q <= in_col;
						pk0_q     <= s_tdata[13:12];
						pk1_q     <= s_tdata[15:14];
						pk2_q     <= s_tdata[16];
						res_q     <= {17'd0, ST_REJECTED};
						state_q   <= S_OUT;
						case (in_act)
							ACT_START: if (in_grid) begin
								start_q <= 1'b1;
								state_q <= S_CLR;
							end
							ACT_ADVANCE: state_q <= S_POP;
							ACT_READ: if (in_grid) state_q <= S_RD;
							default: ;
						endcase
					end
				end
				S_RD: begin
					res_q   <= {cm_rdata[4], cm_rdata[3:0], DIR_LEFT, cmd_col_q, cmd_row_q,
						ST_WALLS};
					state_q <= S_OUT;
				end
				S_SPUSH: begin
					depth_q <= SDW'(1);
					res_q   <= {1'b1, WallsAll, DIR_LEFT, cmd_col_q, cmd_row_q, ST_WALLS};
					state_q <= S_OUT;
				end
				S_POP: begin
					if (depth_q == '0) begin
						res_q   <= {17'd0, ST_FINISHED};
						state_q <= S_OUT;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					{cr_q, cc_q, ord_q, tried_q} <= sk_rdata;
					state_q <= S_TRY;
				end
				S_TRY: begin
					if (tried_q[2]) begin
						depth_q <= depth_q - SDW'(1);
						state_q <= S_POP;
					end else begin
						tried_q <= tried_q + 3'd1;
						d_q     <= try_dir;
						nr_q    <= horiz ? cr_q : RW'(st_nb);
						nc_q    <= horiz ? CW'(st_nb) : cc_q;
						if (st_ok) state_q <= S_CHK;
					end
				end
				S_CHK: state_q <= cm_rdata[4] ? S_TRY : S_CUR;
				S_CUR: begin
					if (depth_q < SDW'(CELLS)) depth_q <= depth_q + SDW'(1);
					res_q   <= {5'd0, d_q, 5'(cc_q), 5'(cr_q), ST_CARVED};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {5'd0, res_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the maze carver against an in-bench copy of the depth-first walk:
// starts, advances, reads and rejected commands over grids of many shapes
// ----------------------------------------------------------------------------
module tb;
	import mbg_pkg::*;

	localparam int NR = 32;
	localparam int NC = 32;
	localparam int WATCH_LIMIT = 200000;

	// lowest bit field last, to match the packing of m_tdata
	typedef struct packed {
		logic       seen;
		logic [3:0] walls;
		logic [1:0] dir;
		logic [4:0] col;
		logic [4:0] row;
		status_t    st;
	} maze_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = 1'b0;
	logic [5:0]  cfg_data = '0;

	always #10 clk = ~clk;

	maze_backtracker_generator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// shadow grid and walk stack
	logic [3:0] walls_q [NR*NC];
	logic       visited_q [NR*NC];
	logic [4:0] stk_r [NR*NC];
	logic [4:0] stk_c [NR*NC];
	logic [1:0] stk_ord [NR*NC][4];
	int         stk_next [NR*NC];
	int         depth;
	logic [5:0] rows_reg, cols_reg;

	maze_result_t expected_results [$];
	int mismatches = 0;
	int carved = 0, finished = 0, beats_sent = 0;
	int send_idle = 0, recv_idle = 0;
	int idle_cycles = 0;

	function automatic int extent(input logic [5:0] v, input int mx);
		if (v == 0) return 1;
		if (v > mx) return mx;
		return v;
	endfunction

	function automatic void clear_grid();
		for (int i = 0; i < NR*NC; i++) begin
			walls_q[i] = 4'hF;
			visited_q[i] = 1'b0;
		end
		depth = 0;
	endfunction

	function automatic void push_cell(input int r, input int c, input logic [1:0] p0,
			input logic [1:0] p1, input logic p2);
		logic [1:0] o [4];
		logic [1:0] t;
		int j;
		int pk [3];
		pk[0] = p0; pk[1] = p1; pk[2] = p2;
		for (int i = 0; i < 4; i++) o[i] = i[1:0];
		for (int i = 0; i < 3; i++) begin
			j = i + pk[i];
			if (j > 3) j = 3;
			t = o[i]; o[i] = o[j]; o[j] = t;
		end
		visited_q[r*NC+c] = 1'b1;
		if (depth < NR*NC) begin
			stk_r[depth] = r[4:0];
			stk_c[depth] = c[4:0];
			for (int i = 0; i < 4; i++) stk_ord[depth][i] = o[i];
			stk_next[depth] = 0;
			depth++;
		end
	endfunction

	// next result of the carver for one command beat
	function automatic maze_result_t carve_step(input logic [23:0] d);
		maze_result_t res;
		action_t a;
		int r, c, nr, nc, top, cr, cc, rr, c2, ni, ci;
		logic [1:0] dir;
		res = '0;
		res.st = ST_REJECTED;
		a = action_t'(d[1:0]);
		r = d[6:2];
		c = d[11:7];
		nr = extent(rows_reg, NR);
		nc = extent(cols_reg, NC);
		case (a)
			ACT_START: begin
				if (r < nr && c < nc) begin
					clear_grid();
					push_cell(r, c, d[13:12], d[15:14], d[16]);
					res.st = ST_WALLS; res.row = r[4:0]; res.col = c[4:0];
					res.walls = 4'hF; res.seen = 1'b1;
				end
			end
			ACT_ADVANCE: begin
				while (depth > 0) begin
					top = depth - 1;
					cr = stk_r[top];
					cc = stk_c[top];
					while (stk_next[top] < 4) begin
						dir = stk_ord[top][stk_next[top]];
						rr = cr + (dir == DIR_UP ? -1 : dir == DIR_DOWN ? 1 : 0);
						c2 = cc + (dir == DIR_LEFT ? -1 : dir == DIR_RIGHT ? 1 : 0);
						stk_next[top]++;
						if (rr >= 0 && rr < nr && c2 >= 0 && c2 < nc
								&& !visited_q[rr*NC+c2]) begin
							ci = cr*NC + cc;
							ni = rr*NC + c2;
							case (dir)
								DIR_LEFT: begin
									walls_q[ci][2] = 1'b0; walls_q[ni][3] = 1'b0;
								end
								DIR_RIGHT: begin
									walls_q[ci][3] = 1'b0; walls_q[ni][2] = 1'b0;
								end
								DIR_UP: begin
									walls_q[ci][0] = 1'b0; walls_q[ni][1] = 1'b0;
								end
								default: begin
									walls_q[ci][1] = 1'b0; walls_q[ni][0] = 1'b0;
								end
							endcase
							push_cell(rr, c2, d[13:12], d[15:14], d[16]);
							res.st = ST_CARVED; res.row = cr[4:0]; res.col = cc[4:0];
							res.dir = dir;
							return res;
						end
					end
					depth--;
				end
				res.st = ST_FINISHED;
			end
			ACT_READ: begin
				if (r < nr && c < nc) begin
					res.st = ST_WALLS; res.row = r[4:0]; res.col = c[4:0];
					res.walls = walls_q[r*NC+c]; res.seen = visited_q[r*NC+c];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// one command beat; prediction is made when the beat is accepted
	task automatic send_command(input action_t a, input int r, input int c,
			input logic [1:0] p0, input logic [1:0] p1, input logic p2);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, p2, p1, p0, c[4:0], r[4:0], a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(carve_step({7'd0, p2, p1, p0, c[4:0], r[4:0], a}));
		beats_sent++;
	endtask

	task automatic send_random(input action_t a);
		send_command(a, $urandom_range(31), $urandom_range(31), 2'($urandom_range(3)),
			2'($urandom_range(3)), 1'($urandom_range(1)));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx) cols_reg = v; else rows_reg = v;
	endtask

	task automatic set_grid(input logic [5:0] r, input logic [5:0] c);
		drain();
		write_reg(1'b0, r);
		write_reg(1'b1, c);
	endtask

	// result checker
	always @(posedge clk) begin
		maze_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = maze_result_t'(m_tdata[18:0]);
			if (got.st == ST_CARVED) carved++;
			if (got.st == ST_FINISHED) finished++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
			end else begin
				want = expected_results.pop_front();
				if (got !== want || m_tdata[23:19] !== 5'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want st=%0d r=%0d c=%0d d=%0d w=%h s=%0d, got st=%0d r=%0d c=%0d d=%0d w=%h s=%0d",
							want.st, want.row, want.col, want.dir, want.walls, want.seen,
							got.st, got.row, got.col, got.dir, got.walls, got.seen);
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk)
		m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCH_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// extremes of fields, every action and the named corner cases
	task automatic test_directed();
		send_command(ACT_ADVANCE, 0, 0, 0, 0, 0);     // advance with no walk
		send_command(ACT_READ, 31, 31, 0, 0, 0);      // read of untouched grid
		send_command(ACT_NONE, 31, 31, 3, 3, 1);      // unknown action
		send_command(ACT_START, 31, 0, 3, 3, 1);      // second pick saturates
		send_command(ACT_ADVANCE, 0, 0, 0, 0, 0);
		send_command(ACT_ADVANCE, 0, 0, 1, 2, 1);
		send_command(ACT_READ, 31, 0, 0, 0, 0);
		send_command(ACT_READ, 0, 31, 0, 0, 0);
		set_grid(6'd3, 6'd4);
		send_command(ACT_START, 3, 0, 0, 0, 0);       // start outside grid
		send_command(ACT_READ, 0, 4, 0, 0, 0);        // read outside grid
		send_command(ACT_START, 2, 3, 2, 1, 0);
		repeat (14) send_command(ACT_ADVANCE, 0, 0, 1, 0, 1);
		send_command(ACT_READ, 2, 3, 0, 0, 0);
		set_grid(6'd0, 6'd63);                        // zero acts as one, clamp
		send_command(ACT_START, 0, 31, 0, 0, 0);
		repeat (3) send_command(ACT_ADVANCE, 0, 0, 3, 2, 1);
	endtask

	// well-formed walks with random content, reads and noise between
	task automatic test_random_walks(input int n);
		int k, pick;
		k = 0;
		while (k < n) begin
			if (k % 150 == 0) begin
				pick = $urandom_range(3);
				case (pick)
					0: set_grid(6'(1 + $urandom_range(5)), 6'(1 + $urandom_range(5)));
					1: set_grid(6'd32, 6'($urandom_range(1, 3)));
					2: set_grid(6'($urandom_range(63)), 6'($urandom_range(63)));
					default: set_grid(6'(2 + $urandom_range(8)), 6'(2 + $urandom_range(8)));
				endcase
				send_command(ACT_START, $urandom_range(extent(rows_reg, NR) - 1),
					$urandom_range(extent(cols_reg, NC) - 1), 2'($urandom_range(3)),
					2'($urandom_range(3)), 1'($urandom_range(1)));
				k++;
			end
			pick = $urandom_range(99);
			if (pick < 70) send_random(ACT_ADVANCE);
			else if (pick < 85)
				send_command(ACT_READ, $urandom_range(extent(rows_reg, NR) - 1),
					$urandom_range(extent(cols_reg, NC) - 1), 0, 0, 0);
			else if (pick < 92) send_random(ACT_READ);
			else if (pick < 96) send_random(ACT_START);
			else send_random(ACT_NONE);
			k++;
		end
	endtask

	initial begin
		clear_grid();
		rows_reg = 6'd32;
		cols_reg = 6'd32;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 34; recv_idle = 46;
		test_directed();
		test_random_walks(250);
		send_idle = 46; recv_idle = 34;
		test_random_walks(250);
		send_idle = 0; recv_idle = 0;
		test_random_walks(250);
		drain();
		$display("sent %0d command beats: %0d passages carved, %0d walks finished",
			beats_sent, carved, finished);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: maze_backtracker_generator.f
sv/mbg_pkg.sv
sv/mbg_ram.sv
sv/mbg_step.sv
sv/maze_backtracker_generator.sv
sim/tb.sv
